// File: rtl/wcc_pkg.sv
// Shared constants and types of the 3x3 window filter.
package wcc_pkg;

  // Frame geometry limits
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;

  // Field and counter widths
  localparam int unsigned PixW    = 8;
  localparam int unsigned DimW    = 11;
  localparam int unsigned ColW    = $clog2(MaxWidth);
  localparam int unsigned RowW    = $clog2(MaxHeight);
  localparam int unsigned CfgW    = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned SumW    = 20;

  localparam logic [PixW-1:0] PixMax = 8'd255;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_KROW0  = 3'd2,
    CFG_KROW1  = 3'd3,
    CFG_KROW2  = 3'd4,
    CFG_MODE   = 3'd5
  } cfg_idx_e;

  // One new window column plus the position flags of the item
  typedef struct packed {
    logic [PixW-1:0] top;
    logic [PixW-1:0] mid;
    logic [PixW-1:0] pix;
    logic            emit;
    logic            row_first;
    logic            col_first;
    logic            col_last;
    logic            last;
  } wcc_col_t;

  // Clamp a geometry register to 1..maxv
  function automatic logic [DimW-1:0] eff_dim(logic [DimW-1:0] v, int unsigned maxv);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimW'(maxv)) begin
      r = DimW'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: rtl/wcc_pix_if.sv
// Input pixel channel: valid/ready with pixel and flush marker.
interface wcc_pix_if;
  logic                     valid;
  logic                     ready;
  logic [wcc_pkg::PixW-1:0] pixel_in;
  logic                     flush;

  modport source (output valid, output pixel_in, output flush, input ready);
  modport sink   (input valid, input pixel_in, input flush, output ready);
endinterface

// File: rtl/wcc_res_if.sv
// Result pixel channel: valid/ready with filtered pixel and frame end flag.
interface wcc_res_if;
  logic                     valid;
  logic                     ready;
  logic [wcc_pkg::PixW-1:0] pixel_out;
  logic                     frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

// File: rtl/wcc_line_buf.sv
// Position counters, two-row line store and the input stage register.
module wcc_line_buf (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [wcc_pkg::DimW-1:0]  width_i,
  input  logic [wcc_pkg::DimW-1:0]  height_i,
  input  logic                      pos_clr_i,
  input  logic                      in_valid_i,
  input  logic [wcc_pkg::PixW-1:0]  in_pixel_i,
  input  logic                      in_flush_i,
  output logic                      in_ready_o,
  output logic                      col_vld_o,
  output wcc_pkg::wcc_col_t         col_o,
  input  logic                      col_adv_i
);
  import wcc_pkg::*;

  logic [ColW-1:0] in_col_q, in_col_d;
  logic [DimW-1:0] in_row_q, in_row_d;
  logic [ColW-1:0] out_col_q, out_col_d;
  logic [RowW-1:0] out_row_q, out_row_d;

  logic            accept;
  logic [PixW-1:0] pix;
  logic            emit, cc_last, cr_last, last, in_col_last;

  // Line store: upper row in the high byte, lower row in the low byte
  logic [2*PixW-1:0] mem [MaxWidth];
  logic [2*PixW-1:0] rd_q;
  logic              fwd_q;
  logic [2*PixW-1:0] fwd_data_q;

  logic            s1_vld_q;
  logic [ColW-1:0] s1_col_q;
  logic [PixW-1:0] s1_pix_q;
  logic            s1_emit_q, s1_row_first_q, s1_col_first_q, s1_col_last_q, s1_last_q;
  logic [PixW-1:0] eff_top, eff_mid;

  assign in_ready_o = !s1_vld_q || col_adv_i;
  assign accept     = in_valid_i && in_ready_o;

  // Zero the pixel for flush items and anything past the frame
  assign pix = (in_flush_i || (in_row_q >= height_i)) ? '0 : in_pixel_i;

  assign emit = ((in_row_q >= DimW'(2)) || ((in_row_q == DimW'(1)) && (in_col_q != '0)))
                && ({1'b0, out_row_q} < height_i);

  assign in_col_last = (DimW'(in_col_q) + DimW'(1)) >= width_i;
  assign cc_last     = (DimW'(out_col_q) + DimW'(1)) >= width_i;
  assign cr_last     = (DimW'(out_row_q) + DimW'(1)) >= height_i;
  assign last        = cr_last && cc_last;

  // Advance input and output positions
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (pos_clr_i || (accept && emit && last)) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (accept) begin
      if (in_col_last) begin
        in_col_d = '0;
        in_row_d = in_row_q + DimW'(1);
      end else begin
        in_col_d = in_col_q + ColW'(1);
      end
      if (emit) begin
        if (cc_last) begin
          out_col_d = '0;
          out_row_d = out_row_q + RowW'(1);
        end else begin
          out_col_d = out_col_q + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      s1_vld_q  <= 1'b0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      if (accept) begin
        s1_vld_q <= 1'b1;
      end else if (col_adv_i) begin
        s1_vld_q <= 1'b0;
      end
    end
  end

  // Resolve the column seen by the stage register, forwarded or stored
  assign {eff_top, eff_mid} = fwd_q ? fwd_data_q : rd_q;

  // Write the held item's shifted column; read the incoming item's column
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      mem[s1_col_q] <= {eff_mid, s1_pix_q};
    end
    if (accept) begin
      rd_q <= mem[in_col_q];
    end
  end

  // Capture the input stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_q          <= s1_vld_q && (s1_col_q == in_col_q);
      fwd_data_q     <= {eff_mid, s1_pix_q};
      s1_col_q       <= in_col_q;
      s1_pix_q       <= pix;
      s1_emit_q      <= emit;
      s1_row_first_q <= (out_row_q == '0);
      s1_col_first_q <= (out_col_q == '0);
      s1_col_last_q  <= cc_last;
      s1_last_q      <= last;
    end
  end

  assign col_vld_o       = s1_vld_q;
  assign col_o.top       = eff_top;
  assign col_o.mid       = eff_mid;
  assign col_o.pix       = s1_pix_q;
  assign col_o.emit      = s1_emit_q;
  assign col_o.row_first = s1_row_first_q;
  assign col_o.col_first = s1_col_first_q;
  assign col_o.col_last  = s1_col_last_q;
  assign col_o.last      = s1_last_q;

endmodule

// File: rtl/wcc_window_mac.sv
// 3x3 window, nine weighted products, saturating sum and result register.
module wcc_window_mac (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [wcc_pkg::CfgW-1:0]  krow0_i,
  input  logic [wcc_pkg::CfgW-1:0]  krow1_i,
  input  logic [wcc_pkg::CfgW-1:0]  krow2_i,
  input  logic                      mode_i,
  input  logic                      col_vld_i,
  input  wcc_pkg::wcc_col_t         col_i,
  output logic                      col_adv_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [wcc_pkg::PixW-1:0]  out_pixel_o,
  output logic                      out_end_o
);
  import wcc_pkg::*;

  logic [PixW-1:0] win1_q [3];
  logic [PixW-1:0] win2_q [3];
  logic [PixW-1:0] ncol   [3];
  logic [CfgW-1:0] krow   [3];
  logic [PixW-1:0] tap    [3][3];
  logic [PixW-1:0] wt     [3][3];
  logic [15:0]     prod   [3][3];
  logic [SumW-1:0] sum_d;
  logic [PixW-1:0] sat_d;

  logic            out_vld_q;
  logic [PixW-1:0] out_pix_q;
  logic            out_end_q;

  assign col_adv_o = col_vld_i && (!col_i.emit || !out_vld_q || out_ready_i);

  assign ncol[0] = col_i.top;
  assign ncol[1] = col_i.mid;
  assign ncol[2] = col_i.pix;
  assign krow[0] = krow0_i;
  assign krow[1] = krow1_i;
  assign krow[2] = krow2_i;

  // Select taps and weights, mask padding, form products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (j == 0) begin
          tap[i][j] = win1_q[i];
        end else if (j == 1) begin
          tap[i][j] = win2_q[i];
        end else begin
          tap[i][j] = ncol[i];
        end
        if ((i == 0 && col_i.row_first) || (j == 0 && col_i.col_first) ||
            (j == 2 && col_i.col_last)) begin
          tap[i][j] = '0;
        end
        if (mode_i) begin
          wt[i][j] = krow[2-i][8*(2-j) +: 8];
        end else begin
          wt[i][j] = krow[i][8*j +: 8];
        end
        prod[i][j] = 16'(tap[i][j]) * 16'(wt[i][j]);
      end
    end
  end

  // Sum the products and clamp
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sum_d = sum_d + SumW'(prod[i][j]);
      end
    end
    sat_d = (sum_d > SumW'(PixMax)) ? PixMax : sum_d[PixW-1:0];
  end

  // Shift the window as each item leaves the input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        win1_q[i] <= '0;
        win2_q[i] <= '0;
      end
    end else if (col_adv_o) begin
      for (int i = 0; i < 3; i++) begin
        win1_q[i] <= win2_q[i];
        win2_q[i] <= ncol[i];
      end
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (col_adv_o && col_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (col_adv_o && col_i.emit) begin
      out_pix_q <= sat_d;
      out_end_q <= col_i.last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_pixel_o = out_pix_q;
  assign out_end_o   = out_end_q;

endmodule

// File: rtl/window_correlate_convolve_3x3_top.sv
// Top level of the streaming 3x3 zero-padded window filter.
//
// Pixels enter on in_if in raster order, one transfer each; results leave on
// out_if in raster order, one pixel per transfer, frame_end set on the last.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while the
// block is idle; writing width or height restarts the frame position.
// After the frame's pixels, send width+1 flush items for the bottom padding.
// Output lags input by width+1 items; the item that completes a window passes
// the input stage, then its result is held in the result register.
// Throughput is one item per cycle while results are taken: the line store
// reads for the incoming item and writes for the held item each cycle.
// Reset clears position counters, window and configuration (1024x1024,
// zero kernel, correlation); line-store contents are undefined but are only
// read for rows above the frame, which are masked.
// When the receiver stalls, the result register holds and the input stage
// still takes one more item; further transfers wait until the result moves.
module window_correlate_convolve_3x3_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [wcc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wcc_pkg::CfgW-1:0]     cfg_data_i,
  wcc_pix_if.sink                      in_if,
  wcc_res_if.source                    out_if
);
  import wcc_pkg::*;

  logic [DimW-1:0] width_q, height_q;
  logic [CfgW-1:0] krow0_q, krow1_q, krow2_q;
  logic            mode_q;
  logic [DimW-1:0] width_eff, height_eff;
  logic            pos_clr;

  wcc_col_t col;
  logic     col_vld, col_adv;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(MaxWidth);
      height_q <= DimW'(MaxHeight);
      krow0_q  <= '0;
      krow1_q  <= '0;
      krow2_q  <= '0;
      mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  width_q  <= cfg_data_i[DimW-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[DimW-1:0];
        CFG_KROW0:  krow0_q  <= cfg_data_i;
        CFG_KROW1:  krow1_q  <= cfg_data_i;
        CFG_KROW2:  krow2_q  <= cfg_data_i;
        CFG_MODE:   mode_q   <= cfg_data_i[0];
        default:    ;
      endcase
    end
  end

  assign pos_clr = cfg_we_i && ((cfg_idx_i == CFG_WIDTH) || (cfg_idx_i == CFG_HEIGHT));

  assign width_eff  = eff_dim(width_q, MaxWidth);
  assign height_eff = eff_dim(height_q, MaxHeight);

  wcc_line_buf u_line_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .width_i    (width_eff),
    .height_i   (height_eff),
    .pos_clr_i  (pos_clr),
    .in_valid_i (in_if.valid),
    .in_pixel_i (in_if.pixel_in),
    .in_flush_i (in_if.flush),
    .in_ready_o (in_if.ready),
    .col_vld_o  (col_vld),
    .col_o      (col),
    .col_adv_i  (col_adv)
  );

  wcc_window_mac u_window_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .krow0_i     (krow0_q),
    .krow1_i     (krow1_q),
    .krow2_i     (krow2_q),
    .mode_i      (mode_q),
    .col_vld_i   (col_vld),
    .col_i       (col),
    .col_adv_o   (col_adv),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_pixel_o (out_if.pixel_out),
    .out_end_o   (out_if.frame_end)
  );

endmodule

// File: bench/tb.sv
// Self-checking testbench of the 3x3 window filter: directed and random frames checked against a predictor.
module tb;
  import wcc_pkg::*;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            flush;
  } pix_item_t;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            frame_end;
  } res_item_t;

  // Slowest run: ~1.6k items, each with random idling and stalling, plus drains
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned RandomItems = 1350;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned HoldAfter   = 200;
  localparam int unsigned HoldCycles  = 300;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;

  wcc_pix_if pix_ch ();
  wcc_res_if res_ch ();

  window_correlate_convolve_3x3_top dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_if  (pix_ch),
    .out_if (res_ch)
  );

  pix_item_t   pixel_q[$];
  res_item_t   filtered_q[$];
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned sent;
  int unsigned src_odds;
  int unsigned snk_odds;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned seen_xfers;
  bit          hold_used;

  // Filter state as the block should hold it
  logic [DimW-1:0] width_reg;
  logic [DimW-1:0] height_reg;
  logic [CfgW-1:0] kernel_rows [3];
  logic            conv_mode;
  logic [PixW-1:0] upper_line [MaxWidth];
  logic [PixW-1:0] lower_line [MaxWidth];
  logic [PixW-1:0] win [3][3];
  int unsigned     in_col, in_row, out_col, out_row;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned dim_limit(logic [DimW-1:0] v, int unsigned cap);
    if (v == '0) return 1;
    if (v > cap) return cap;
    return 32'(v);
  endfunction

  // Weight applied to window cell (i,j); convolution reads the kernel flipped in rows and columns
  function automatic int unsigned weight(int unsigned i, int unsigned j);
    int unsigned ri, rj;
    ri = conv_mode ? 2 - i : i;
    rj = conv_mode ? 2 - j : j;
    return 32'(kernel_rows[ri][8*rj +: 8]);
  endfunction

  function automatic void restart_frame();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  // Advance the window by one accepted pixel and queue the result it completes
  function automatic void filter_pixel(pix_item_t it);
    int unsigned     w, h, sum, i, j, r;
    logic [PixW-1:0] p, top, mid;
    logic            emit, last;
    res_item_t       res;
    w = dim_limit(width_reg, MaxWidth);
    h = dim_limit(height_reg, MaxHeight);
    p = (it.flush || in_row >= h) ? '0 : it.pixel;
    top = upper_line[in_col];
    mid = lower_line[in_col];
    upper_line[in_col] = mid;
    lower_line[in_col] = p;
    for (r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = p;
    emit = (in_row >= 2 || (in_row == 1 && in_col >= 1)) && out_row < h;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (emit) begin
      // Mask window rows and columns that fall outside the frame
      sum = 0;
      for (i = 0; i < 3; i++) begin
        if (!(i == 0 && out_row == 0)) begin
          for (j = 0; j < 3; j++) begin
            if (!(j == 0 && out_col == 0) && !(j == 2 && out_col + 1 >= w)) begin
              sum += weight(i, j) * win[i][j];
            end
          end
        end
      end
      last = (out_row + 1 >= h) && (out_col + 1 >= w);
      res.pixel     = (sum > PixMax) ? PixMax : PixW'(sum);
      res.frame_end = last;
      filtered_q.push_back(res);
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
      if (last) restart_frame();
    end
  endfunction

  function automatic void note_mismatch(string what);
    mismatches++;
    if (mismatches <= MaxReports) $display("cycle %0d: %s", cycles, what);
  endfunction

  // Input driver: hold an offered pixel until its transfer, idle in random bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_ch.valid    <= 1'b0;
      pix_ch.pixel_in <= '0;
      pix_ch.flush    <= 1'b0;
      gap_left = 0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        filter_pixel(pixel_q.pop_front());
      end
      if (!pix_ch.valid || pix_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          pix_ch.valid <= 1'b0;
        end else if (src_odds != 0 && $urandom_range(1, src_odds) == 1) begin
          gap_left = $urandom_range(0, 15);
          pix_ch.valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          pix_ch.valid    <= 1'b1;
          pix_ch.pixel_in <= pixel_q[0].pixel;
          pix_ch.flush    <= pixel_q[0].flush;
        end else begin
          pix_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once enough pixels went in, so the block backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      seen_xfers = 0;
      hold_used  = 1'b0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) seen_xfers++;
      if (!hold_used && seen_xfers == HoldAfter) begin
        hold_left <= HoldCycles;
        hold_used = 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Result monitor: check each transfer against the oldest expected pixel
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (filtered_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result pixel %0d frame_end %0d",
                                  res_ch.pixel_out, res_ch.frame_end));
        end else if (res_ch.pixel_out !== filtered_q[0].pixel ||
                     res_ch.frame_end !== filtered_q[0].frame_end) begin
          note_mismatch($sformatf("pixel %0d frame_end %0d, expected %0d frame_end %0d",
                                  res_ch.pixel_out, res_ch.frame_end,
                                  filtered_q[0].pixel, filtered_q[0].frame_end));
          void'(filtered_q.pop_front());
        end else begin
          void'(filtered_q.pop_front());
        end
      end
      if (hold_left != 0) begin
        res_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (snk_odds != 0 && $urandom_range(1, snk_odds) == 1) begin
        stall_left = $urandom_range(0, 15);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("** window_correlate_convolve_3x3_top: FAILED **");
      $finish;
    end
  end

  // Register write; the caller drops the enable after its last write
  task automatic cfg_write(cfg_idx_e idx, logic [CfgW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_WIDTH: begin
        width_reg = data[DimW-1:0];
        restart_frame();
      end
      CFG_HEIGHT: begin
        height_reg = data[DimW-1:0];
        restart_frame();
      end
      CFG_KROW0: kernel_rows[0] = data;
      CFG_KROW1: kernel_rows[1] = data;
      CFG_KROW2: kernel_rows[2] = data;
      CFG_MODE:  conv_mode = data[0];
      default: ;
    endcase
  endtask

  task automatic cfg_close();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h);
    cfg_write(CFG_WIDTH, CfgW'(w));
    cfg_write(CFG_HEIGHT, CfgW'(h));
    cfg_close();
  endtask

  task automatic set_kernel(logic [CfgW-1:0] k0, logic [CfgW-1:0] k1,
                            logic [CfgW-1:0] k2, logic mode);
    cfg_write(CFG_KROW0, k0);
    cfg_write(CFG_KROW1, k1);
    cfg_write(CFG_KROW2, k2);
    cfg_write(CFG_MODE, CfgW'(mode));
    cfg_close();
  endtask

  // Wait until every pixel went in and every result came out, then let the pipe drain
  task automatic settle();
    do @(posedge clk_i);
    while (pixel_q.size() != 0 || filtered_q.size() != 0 || pix_ch.valid);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic void add_pixel(logic [PixW-1:0] p, logic f);
    pix_item_t it;
    it.pixel = p;
    it.flush = f;
    pixel_q.push_back(it);
  endfunction

  function automatic logic [PixW-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return PixMax;
      default: return PixW'($urandom());
    endcase
  endfunction

  // Mostly sparse small weights so that many sums stay below saturation
  function automatic logic [CfgW-1:0] pick_kernel_row();
    logic [CfgW-1:0] row;
    int unsigned     k;
    for (k = 0; k < 3; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: row[8*k +: 8] = '0;
        5, 6:          row[8*k +: 8] = 8'd1;
        7, 8:          row[8*k +: 8] = 8'($urandom_range(0, 7));
        default:       row[8*k +: 8] = 8'($urandom());
      endcase
    end
    return row;
  endfunction

  function automatic int unsigned pick_odds();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 3;
      2:       return 8;
      default: return 20;
    endcase
  endfunction

  // Queue one frame plus its bottom padding; noisy frames carry stray flags or stop early
  function automatic int unsigned push_frame(int unsigned w, int unsigned h, bit noisy);
    int unsigned n, total, cut;
    total = w * h + w + 1;
    cut   = (noisy && $urandom_range(0, 3) == 0) ? $urandom_range(1, total) : total;
    for (n = 0; n < cut; n++) begin
      if (n < w * h) begin
        add_pixel(pick_pixel(), noisy && $urandom_range(0, 15) == 0);
      end else begin
        add_pixel(pick_pixel(), !(noisy && $urandom_range(0, 3) == 0));
      end
    end
    return cut;
  endfunction

  // Random phases with fresh geometry, kernel and idling until the item count is reached
  task automatic random_phases(int unsigned target);
    int unsigned w, h, frames;
    while (sent < target) begin
      settle();
      src_odds = pick_odds();
      snk_odds = pick_odds();
      if ($urandom_range(0, 4) != 0) begin
        w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
        h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        set_geometry(w, h);
      end
      if ($urandom_range(0, 2) != 0) begin
        set_kernel(pick_kernel_row(), pick_kernel_row(), pick_kernel_row(),
                   1'($urandom_range(0, 1)));
      end
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        sent += push_frame(dim_limit(width_reg, MaxWidth), dim_limit(height_reg, MaxHeight),
                           $urandom_range(0, 2) == 0);
      end
    end
  endtask

  initial begin
    int unsigned k;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_WIDTH;
    cfg_data_i      = '0;
    pix_ch.valid    = 1'b0;
    pix_ch.pixel_in = '0;
    pix_ch.flush    = 1'b0;
    res_ch.ready    = 1'b0;
    src_odds        = 0;
    snk_odds        = 0;
    sent            = 0;
    mismatches      = 0;
    cycles          = 0;

    // Predictor at its reset state
    width_reg  = DimW'(MaxWidth);
    height_reg = DimW'(MaxHeight);
    for (k = 0; k < 3; k++) kernel_rows[k] = '0;
    conv_mode = 1'b0;
    for (k = 0; k < MaxWidth; k++) begin
      upper_line[k] = '0;
      lower_line[k] = '0;
    end
    for (k = 0; k < 9; k++) win[k / 3][k % 3] = '0;
    restart_frame();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero geometry acts as a single pixel; the reset kernel gives zero
    set_geometry(0, 0);
    add_pixel(8'd255, 1'b0);
    add_pixel(8'd255, 1'b1);
    add_pixel(8'd0, 1'b1);
    settle();

    // Full weights on a bright 2x2 frame saturate every output
    set_kernel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
    set_geometry(2, 2);
    repeat (4) add_pixel(8'd255, 1'b0);
    repeat (3) add_pixel(8'd255, 1'b1);
    settle();

    // Convolution with an asymmetric kernel, a flush inside the frame,
    // and a plain pixel after the frame that must count as zero
    set_kernel(24'h030201, 24'h060504, 24'h090807, 1'b1);
    set_geometry(3, 2);
    add_pixel(8'd1, 1'b0);
    add_pixel(8'd2, 1'b0);
    add_pixel(8'd3, 1'b0);
    add_pixel(8'd200, 1'b1);
    add_pixel(8'd3, 1'b0);
    add_pixel(8'd1, 1'b0);
    add_pixel(8'd77, 1'b0);
    add_pixel(8'd9, 1'b1);
    add_pixel(8'd250, 1'b1);
    add_pixel(8'd0, 1'b1);
    settle();

    random_phases(RandomItems / 8);

    // Tallest column, from an out-of-range height register value
    settle();
    set_kernel(pick_kernel_row(), pick_kernel_row(), pick_kernel_row(), 1'b1);
    set_geometry(1, 11'h7FF);
    sent += push_frame(1, MaxHeight, 1'b0);

    random_phases(RandomItems);

    // Close with back-to-back clean frames and no idling on either side
    src_odds = 0;
    snk_odds = 0;
    settle();
    set_geometry(5, 4);
    set_kernel(pick_kernel_row(), pick_kernel_row(), pick_kernel_row(),
               1'($urandom_range(0, 1)));
    repeat (2) void'(push_frame(5, 4, 1'b0));
    settle();

    if (mismatches == 0) begin
      $display("** window_correlate_convolve_3x3_top: PASSED **");
    end else begin
      $display("** window_correlate_convolve_3x3_top: FAILED **");
    end
    $finish;
  end

endmodule

// File: window_correlate_convolve_3x3_top.f
rtl/wcc_pkg.sv
rtl/wcc_pix_if.sv
rtl/wcc_res_if.sv
rtl/wcc_line_buf.sv
rtl/wcc_window_mac.sv
rtl/window_correlate_convolve_3x3_top.sv
bench/tb.sv
